// ===== hdl/periodic_message_slot_scheduler_defines.svh =====
// Assertion macros for the periodic message slot scheduler.
`ifndef PERIODIC_MESSAGE_SLOT_SCHEDULER_DEFINES_SVH
`define PERIODIC_MESSAGE_SLOT_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define PMSS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define PMSS_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`else

`define PMSS_ASSERT(lbl, prop, msg)
`define PMSS_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// ===== hdl/pmss_pkg.sv =====
// Shared types, constants and helpers of the periodic message slot scheduler.
`timescale 1ns / 1ps

package pmss_pkg;

   // Slot count default and register file geometry
   localparam int DEFAULT_SLOTS = 6;
   localparam int MAX_SLOTS     = 8;
   localparam int PERIOD_REGS   = 6;
   localparam int CSR_ADDR_W    = 5;
   localparam int OUTCOME_W     = 18;
   localparam int STAGGER_MS    = 50;

   // Register indexes
   localparam logic [2:0] REG_RETRY = 3'd6;

   // Register reset values
   localparam logic [15:0] PERIOD_RESET = 16'd1000;
   localparam logic [15:0] RETRY_RESET  = 16'd100;

   // Encoder outcome codes
   localparam logic [2:0] OC_OK       = 3'd0;
   localparam logic [2:0] OC_IDLE     = 3'd2;
   localparam logic [2:0] OC_BUSY     = 3'd4;
   localparam logic [2:0] OC_IO_ERROR = 3'd5;

   typedef logic [PERIOD_REGS-1:0][15:0] period_arr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FINISH
   } pmss_state_type;

   // Controller commands to the datapath
   typedef struct packed {
      logic init;
      logic latch;
      logic check;
      logic finish;
   } pmss_cmd_type;

   // Datapath status to the controller
   typedef struct packed {
      logic due;
      logic term;
      logic pend_valid;
      logic out_free;
   } pmss_sts_type;

   // One result word
   typedef struct packed {
      logic        attempted;
      logic [2:0]  slot;
      logic [2:0]  outcome;
      logic [31:0] next_deadline;
      logic [31:0] ok_count;
      logic [2:0]  run_status;
      logic        is_last;
   } rsp_word_type;

   // True for outcomes that end a pass
   function automatic logic is_term(input logic [2:0] oc);
      return (oc == OC_OK) || (oc == OC_BUSY) || (oc == OC_IO_ERROR);
   endfunction

endpackage

// ===== hdl/pmss_req_if.sv =====
// Request channel: one word per start or run item.
`timescale 1ns / 1ps

interface pmss_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [31:0] now_ms;
   logic [17:0] slot_outcomes;

   modport source (output valid, action, now_ms, slot_outcomes, input ready);
   modport sink (input valid, action, now_ms, slot_outcomes, output ready);
endinterface

// ===== hdl/pmss_rsp_if.sv =====
// Response channel: one word per due slot, or one idle word per pass.
`timescale 1ns / 1ps

interface pmss_rsp_if;
   logic        valid;
   logic        ready;
   logic        attempted;
   logic [2:0]  slot;
   logic [2:0]  outcome;
   logic [31:0] next_deadline;
   logic [31:0] ok_count;
   logic [2:0]  run_status;
   logic        is_last;

   modport source (output valid, attempted, slot, outcome, next_deadline,
                   ok_count, run_status, is_last, input ready);
   modport sink (input valid, attempted, slot, outcome, next_deadline,
                 ok_count, run_status, is_last, output ready);
endinterface

// ===== hdl/pmss_csr.sv =====
// Period and retry registers behind the APB-style port.
`timescale 1ns / 1ps

module pmss_csr
   import pmss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output period_arr_type        period,
   output logic [15:0]           retry
);

   period_arr_type period_ff, period_in;
   logic [15:0]    retry_ff, retry_in;
   logic [2:0]     idx;
   logic           wr;

   assign idx    = paddr[CSR_ADDR_W-1:2];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   // Decode the write
   always_comb begin
      period_in = period_ff;
      retry_in  = retry_ff;
      if (wr) begin
         if (idx == REG_RETRY) begin
            retry_in = pwdata[15:0];
         end else if (32'(idx) < PERIOD_REGS) begin
            period_in[idx] = pwdata[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= {PERIOD_REGS{PERIOD_RESET}};
         retry_ff  <= RETRY_RESET;
      end else begin
         period_ff <= period_in;
         retry_ff  <= retry_in;
      end
   end

   // Read back
   always_comb begin
      if (idx == REG_RETRY) begin
         prdata = {16'd0, retry_ff};
      end else if (32'(idx) < PERIOD_REGS) begin
         prdata = {16'd0, period_ff[idx]};
      end else begin
         prdata = '0;
      end
   end

   assign period = period_ff;
   assign retry  = retry_ff;

endmodule

// ===== hdl/pmss_ctrl.sv =====
// Pass sequencer: accepts items and steps the datapath one slot a cycle unless a full output register holds it.
`timescale 1ns / 1ps

module pmss_ctrl
   import pmss_pkg::*;
#(
   parameter int SLOTS = DEFAULT_SLOTS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_action,
   output logic         req_ready,
   input  pmss_sts_type sts,
   output pmss_cmd_type cmd
);

   localparam int CHK_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   pmss_state_type   state_ff, state_in;
   logic [CHK_W-1:0] checked_ff, checked_in;
   logic             last_check;
   logic             can_check;

   assign last_check = (checked_ff == CHK_W'(SLOTS - 1));
   // A second due slot must wait for the output register to drain
   assign can_check  = !sts.due || !sts.pend_valid || sts.out_free;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_action) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (can_check && ((sts.due && sts.term) || last_check)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.init   = req_valid && !req_action;
            cmd.latch  = req_valid && req_action;
         end
         ST_CHECK: begin
            cmd.check  = can_check;
         end
         ST_FINISH: begin
            cmd.finish = sts.out_free;
         end
         default: begin
            req_ready  = 1'b0;
         end
      endcase
   end

   // Count slots checked in this pass
   always_comb begin
      checked_in = checked_ff;
      if (cmd.latch) begin
         checked_in = '0;
      end else if (cmd.check) begin
         checked_in = checked_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         checked_ff <= '0;
      end else begin
         state_ff   <= state_in;
         checked_ff <= checked_in;
      end
   end

endmodule

// ===== hdl/pmss_dp.sv =====
// Slot state, deadline compare and update, pending and output words.
`timescale 1ns / 1ps

module pmss_dp
   import pmss_pkg::*;
#(
   parameter int SLOTS = DEFAULT_SLOTS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pmss_cmd_type         cmd,
   output pmss_sts_type         sts,
   input  logic [31:0]          req_now_ms,
   input  logic [OUTCOME_W-1:0] req_slot_outcomes,
   input  period_arr_type       period,
   input  logic [15:0]          retry,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output rsp_word_type         rsp_word
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [31:0]          now_ff, now_in;
   logic [OUTCOME_W-1:0] oc_ff, oc_in;
   logic [31:0]          dl_ff [SLOTS];
   logic [31:0]          dl_in [SLOTS];
   logic [31:0]          cnt_ff [SLOTS];
   logic [31:0]          cnt_in [SLOTS];
   logic [SLOT_W-1:0]    ptr_ff, ptr_in;
   rsp_word_type         pend_ff, pend_in;
   logic                 pend_valid_ff, pend_valid_in;
   rsp_word_type         out_ff, out_in;
   logic                 out_valid_ff, out_valid_in;

   logic [3*MAX_SLOTS-1:0] oc_ext;
   logic [2:0]             cur_oc;
   logic [15:0]            cur_per;
   logic [31:0]            cur_dl;
   logic [31:0]            cur_cnt;
   logic [31:0]            diff;
   logic                   due;
   logic                   ok;
   logic [31:0]            new_dl;
   logic [31:0]            new_cnt;
   logic                   out_free;
   rsp_word_type           last_word;

   // Select the current slot's outcome and period
   assign oc_ext = (3*MAX_SLOTS)'(oc_ff);
   always_comb begin
      cur_oc  = OC_OK;
      cur_per = period[0];
      for (int i = 0; i < SLOTS; i++) begin
         if (ptr_ff == SLOT_W'(i)) begin
            cur_oc  = oc_ext[3*i +: 3];
            cur_per = period[i % PERIOD_REGS];
         end
      end
   end

   // Wrap-safe deadline test and slot update
   assign cur_dl   = dl_ff[ptr_ff];
   assign cur_cnt  = cnt_ff[ptr_ff];
   assign diff     = now_ff - cur_dl;
   assign due      = !diff[31];
   assign ok       = (cur_oc == OC_OK);
   assign new_dl   = now_ff + 32'(ok ? cur_per : retry);
   assign new_cnt  = cur_cnt + 32'(ok);
   assign out_free = !out_valid_ff || rsp_ready;

   assign sts.due        = due;
   assign sts.term       = is_term(cur_oc);
   assign sts.pend_valid = pend_valid_ff;
   assign sts.out_free   = out_free;

   // Close the pass: mark the pending word last, or report idle
   always_comb begin
      last_word = '0;
      if (pend_valid_ff) begin
         last_word            = pend_ff;
         last_word.is_last    = 1'b1;
         last_word.run_status = is_term(pend_ff.outcome) ? pend_ff.outcome : OC_IDLE;
      end else begin
         last_word.run_status = OC_IDLE;
         last_word.is_last    = 1'b1;
      end
   end

   always_comb begin
      now_in        = now_ff;
      oc_in         = oc_ff;
      dl_in         = dl_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;

      // Stagger deadlines, clear counts and reset the pointer
      if (cmd.init) begin
         for (int i = 0; i < SLOTS; i++) begin
            dl_in[i]  = req_now_ms + 32'(STAGGER_MS * i);
            cnt_in[i] = '0;
         end
         ptr_in = '0;
      end

      // Hold the pass inputs
      if (cmd.latch) begin
         now_in = req_now_ms;
         oc_in  = req_slot_outcomes;
      end

      // Advance the pointer; update a due slot and shift the pending word out
      if (cmd.check) begin
         ptr_in = (ptr_ff == SLOT_W'(SLOTS - 1)) ? '0 : ptr_ff + 1'b1;
         if (due) begin
            dl_in[ptr_ff]  = new_dl;
            cnt_in[ptr_ff] = new_cnt;
            pend_in.attempted     = 1'b1;
            pend_in.slot          = 3'(ptr_ff);
            pend_in.outcome       = cur_oc;
            pend_in.next_deadline = new_dl;
            pend_in.ok_count      = new_cnt;
            pend_in.run_status    = '0;
            pend_in.is_last       = 1'b0;
            pend_valid_in         = 1'b1;
            if (pend_valid_ff) begin
               out_in       = pend_ff;
               out_valid_in = 1'b1;
            end
         end
      end

      // Emit the final word of the pass
      if (cmd.finish) begin
         out_in        = last_word;
         out_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            dl_ff[i]  <= '0;
            cnt_ff[i] <= '0;
         end
         ptr_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         dl_ff         <= dl_in;
         cnt_ff        <= cnt_in;
         ptr_ff        <= ptr_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      now_ff  <= now_in;
      oc_ff   <= oc_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

endmodule

// ===== hdl/periodic_message_slot_scheduler.sv =====
// Top level of the periodic message slot scheduler.
//
//   channel  | direction | word
//   ---------+-----------+-----------------------------------------------
//   req_if   | in        | action, now_ms, slot_outcomes
//   rsp_if   | out       | attempted, slot, outcome, next_deadline,
//            |           | ok_count, run_status, is_last
//   p*       | in/out    | APB-style period and retry registers
//
// A start word is taken in the idle state. A run word is accepted, then one
// slot a cycle is checked (up to SLOTS) by the single slot update unit, then
// the pass closes. Reset is synchronous and clears all slot state at once.
// When a second due slot finds the output register still full, the pass
// waits; req_if is not ready until the pass has closed.
`timescale 1ns / 1ps
`include "periodic_message_slot_scheduler_defines.svh"

module periodic_message_slot_scheduler
   import pmss_pkg::*;
#(
   parameter int SLOTS = DEFAULT_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   pmss_req_if.sink              req_if,
   pmss_rsp_if.source            rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   pmss_cmd_type   cmd;
   pmss_sts_type   sts;
   period_arr_type period;
   logic [15:0]    retry;
   rsp_word_type   rsp_word;
   logic           rsp_valid;

   pmss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .period  (period),
      .retry   (retry)
   );

   pmss_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_action (req_if.action),
      .req_ready  (req_if.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pmss_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_now_ms        (req_if.now_ms),
      .req_slot_outcomes (req_if.slot_outcomes),
      .period            (period),
      .retry             (retry),
      .rsp_ready         (rsp_if.ready),
      .rsp_valid         (rsp_valid),
      .rsp_word          (rsp_word)
   );

   // Drive the result channel from the output register
   assign rsp_if.valid         = rsp_valid;
   assign rsp_if.attempted     = rsp_word.attempted;
   assign rsp_if.slot          = rsp_word.slot;
   assign rsp_if.outcome       = rsp_word.outcome;
   assign rsp_if.next_deadline = rsp_word.next_deadline;
   assign rsp_if.ok_count      = rsp_word.ok_count;
   assign rsp_if.run_status    = rsp_word.run_status;
   assign rsp_if.is_last       = rsp_word.is_last;

   // No pending word may outlive its pass
   `PMSS_ASSERT_NEVER(a_idle_no_pending, req_if.ready && sts.pend_valid, "pending while idle")
   // Closing a pass puts a last word on the channel
   `PMSS_ASSERT(a_finish_last, cmd.finish |=> rsp_if.valid && rsp_if.is_last, "no last word")
   // A word that is not last always reports a due slot
   `PMSS_ASSERT(a_mid_attempted, rsp_if.valid && !rsp_if.is_last |-> rsp_if.attempted, "idle mid")
   // Reported slot lies within the slot count
   `PMSS_ASSERT(a_slot_range, rsp_if.valid |-> ({1'b0, rsp_if.slot} < 4'(SLOTS)), "bad slot")

endmodule
